// ----- hw/rtl/odo_pkg.sv -----
`default_nettype none
package odo_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 16;
   localparam int unsigned ANGLE_BITS_DEF   = 32;

   localparam logic [23:0] FOURPI_Q20      = 24'd13176795;
   localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;

   localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
   localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

   typedef enum logic [1:0] {
      CSR_LIN_COEF    = 2'd0,
      CSR_ANG_COEF    = 2'd1,
      CSR_STEP_PERIOD = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_NONE = 4'd0,
      OP_LIN  = 4'd1,
      OP_P1   = 4'd2,
      OP_TLO  = 4'd3,
      OP_THI  = 4'd4,
      OP_HLO  = 4'd5,
      OP_HHI  = 4'd6,
      OP_HEAD = 4'd7,
      OP_HUPD = 4'd8,
      OP_MX1  = 4'd9,
      OP_MY1  = 4'd10,
      OP_MX2  = 4'd11,
      OP_MY2  = 4'd12,
      OP_PY   = 4'd13
   } op_type;

   typedef struct packed {
      op_type op;
      logic   cordic_start;
      logic   load_in;
      logic   load_out;
   } odo_cmd_type;

   typedef struct packed {
      logic cordic_done;
   } odo_sts_type;

   function automatic logic [31:0] atan_at(input logic [4:0] idx);
      logic [31:0] v;
      begin
         case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
         endcase
         return v;
      end
   endfunction

   // sign * round(mag / 2^sh), half away from zero, saturated
   function automatic logic [31:0] round_sat(input logic neg, input logic [64:0] mag,
                                             input int unsigned sh);
      logic [65:0] q;
      begin
         q = (66'(mag) + (66'(1) << (sh - 1))) >> sh;
         if (neg) begin
            return (q >= 66'h80000000) ? 32'h80000000 : 32'(66'(0) - q);
         end
         return (q > 66'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      end
   endfunction

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      begin
         if (v > SAT_MAX) begin
            return 32'h7FFFFFFF;
         end
         if (v < SAT_MIN) begin
            return 32'h80000000;
         end
         return v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/odo_cordic.sv -----
`default_nettype none
module odo_cordic import odo_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] angle_a,
   input  wire logic [31:0] angle_b,
   output logic             done,
   output logic [31:0]      cos_a,
   output logic [31:0]      sin_a,
   output logic [31:0]      cos_b,
   output logic [31:0]      sin_b
);

   localparam int unsigned CW = $clog2(CORDIC_STEPS + 1);

   logic signed [33:0] x_ff [2];
   logic signed [33:0] y_ff [2];
   logic [31:0]        z_ff [2];
   logic [1:0]         flip_ff;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [31:0]        cos_ff [2];
   logic [31:0]        sin_ff [2];

   logic signed [33:0] sx_w [2];
   logic signed [33:0] sy_w [2];
   logic [31:0]        ang_w [2];
   logic [31:0]        atan_w;

   assign ang_w[0] = angle_a;
   assign ang_w[1] = angle_b;
   assign atan_w   = atan_at(5'(cnt_ff));

   always_comb begin
      for (int ln = 0; ln < 2; ln++) begin
         sx_w[ln] = x_ff[ln] >>> cnt_ff;
         sy_w[ln] = y_ff[ln] >>> cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CW'(CORDIC_STEPS)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int ln = 0; ln < 2; ln++) begin
         if (start) begin
            flip_ff[ln] <= (ang_w[ln] + 32'h40000000) >> 31 != 32'd0;
            z_ff[ln]    <= ((ang_w[ln] + 32'h40000000) >> 31 != 32'd0)
                           ? ang_w[ln] + 32'h80000000 : ang_w[ln];
            x_ff[ln]    <= CORDIC_GAIN_Q30;
            y_ff[ln]    <= '0;
         end else if (busy_ff && (cnt_ff != CW'(CORDIC_STEPS))) begin
            if (!z_ff[ln][31]) begin
               x_ff[ln] <= x_ff[ln] - sy_w[ln];
               y_ff[ln] <= y_ff[ln] + sx_w[ln];
               z_ff[ln] <= z_ff[ln] - atan_w;
            end else begin
               x_ff[ln] <= x_ff[ln] + sy_w[ln];
               y_ff[ln] <= y_ff[ln] - sx_w[ln];
               z_ff[ln] <= z_ff[ln] + atan_w;
            end
         end else if (busy_ff) begin
            cos_ff[ln] <= sat32(flip_ff[ln] ? -36'(x_ff[ln]) : 36'(x_ff[ln]));
            sin_ff[ln] <= sat32(flip_ff[ln] ? -36'(y_ff[ln]) : 36'(y_ff[ln]));
         end
      end
   end

   assign done  = done_ff;
   assign cos_a = cos_ff[0];
   assign sin_a = sin_ff[0];
   assign cos_b = cos_ff[1];
   assign sin_b = sin_ff[1];

endmodule
`default_nettype wire

// ----- hw/rtl/odo_dp.sv -----
`default_nettype none
module odo_dp import odo_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int unsigned ANGLE_BITS   = ANGLE_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire odo_cmd_type  cmd,
   output odo_sts_type       sts,
   input  wire logic [31:0]  req_tdata,
   input  wire logic [23:0]  lin_coef,
   input  wire logic [23:0]  ang_coef,
   input  wire logic [23:0]  step_period,
   output logic [159:0]      rsp_tdata
);

   logic signed [15:0]     l_ff, r_ff;
   logic signed [66:0]     prod_ff;
   logic [40:0]            p1_ff;
   logic [47:0]            tacc_ff;
   logic [47:0]            hacc_ff;
   logic [ANGLE_BITS-1:0]  hd_ff;
   logic [ANGLE_BITS-1:0]  heading_ff;
   logic [31:0]            lin_ff, turn_ff, posx_ff, posy_ff;
   logic signed [33:0]     tx_ff, ty_ff;
   logic [159:0]           out_ff;

   logic signed [16:0] diff_w, sum_w;
   logic [16:0]        adiff_w, asum_w;
   logic signed [33:0] mul_a;
   logic signed [32:0] mul_b;
   logic [47:0]        mag48_w, sgn48_w;
   logic signed [66:0] tr_w;
   logic signed [33:0] t_w;
   logic signed [66:0] dr_w;
   logic signed [35:0] d_w;
   logic [31:0]        pos_sel_w;
   logic [31:0]        pos_new_w;
   logic [31:0]        a32_w;
   logic [31:0]        cos_h, sin_h, cos_q, sin_q;
   logic               cdone;

   assign diff_w  = {r_ff[15], r_ff} - {l_ff[15], l_ff};
   assign sum_w   = {r_ff[15], r_ff} + {l_ff[15], l_ff};
   assign adiff_w = diff_w[16] ? 17'(-diff_w) : 17'(diff_w);
   assign asum_w  = sum_w[16] ? 17'(-sum_w) : 17'(sum_w);

   always_comb begin
      case (cmd.op)
         OP_LIN: begin
            mul_a = {17'b0, adiff_w};
            mul_b = {9'b0, lin_coef};
         end
         OP_P1: begin
            mul_a = {17'b0, asum_w};
            mul_b = {9'b0, ang_coef};
         end
         OP_TLO: begin
            mul_a = {10'b0, prod_ff[23:0]};
            mul_b = {9'b0, FOURPI_Q20};
         end
         OP_THI: begin
            mul_a = {17'b0, p1_ff[40:24]};
            mul_b = {9'b0, FOURPI_Q20};
         end
         OP_HLO: begin
            mul_a = {10'b0, p1_ff[23:0]};
            mul_b = {9'b0, step_period};
         end
         OP_HHI: begin
            mul_a = {17'b0, p1_ff[40:24]};
            mul_b = {9'b0, step_period};
         end
         OP_MX1: begin
            mul_a = {{2{lin_ff[31]}}, lin_ff};
            mul_b = {cos_h[31], cos_h};
         end
         OP_MY1: begin
            mul_a = {{2{lin_ff[31]}}, lin_ff};
            mul_b = {sin_h[31], sin_h};
         end
         OP_MX2: begin
            mul_a = tx_ff;
            mul_b = {9'b0, step_period};
         end
         OP_MY2: begin
            mul_a = ty_ff;
            mul_b = {9'b0, step_period};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mag48_w   = hacc_ff + {prod_ff[23:0], 24'b0};
   assign sgn48_w   = sum_w[16] ? 48'(48'd0 - mag48_w) : mag48_w;
   assign tr_w      = prod_ff + (67'sd1 <<< 29);
   assign t_w       = 34'(tr_w >>> 30);
   assign dr_w      = prod_ff + (67'sd1 <<< 23);
   assign d_w       = 36'(dr_w >>> 24);
   assign pos_sel_w = (cmd.op == OP_PY) ? posy_ff : posx_ff;
   assign pos_new_w = sat32(36'($signed(pos_sel_w)) + d_w);
   assign a32_w     = 32'(heading_ff) << (32 - ANGLE_BITS);

   function automatic logic [15:0] to_q15(input logic [31:0] v);
      logic signed [33:0] s;
      begin
         s = ($signed(34'($signed(v))) + 34'sd16384) >>> 15;
         if (s > 34'sd32767) begin
            return 16'h7FFF;
         end
         if (s < -34'sd32768) begin
            return 16'h8000;
         end
         return s[15:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load_in) begin
         l_ff <= req_tdata[15:0];
         r_ff <= req_tdata[31:16];
      end
      case (cmd.op)
         OP_P1:   lin_ff  <= round_sat(diff_w[16], 65'(prod_ff[40:0]), 8);
         OP_TLO:  p1_ff   <= prod_ff[40:0];
         OP_THI:  tacc_ff <= prod_ff[47:0];
         OP_HLO:  turn_ff <= round_sat(sum_w[16],
                                       65'(tacc_ff) + (65'(prod_ff[40:0]) << 24), 28);
         OP_HHI:  hacc_ff <= prod_ff[47:0];
         OP_HEAD: hd_ff   <= sgn48_w[47 -: ANGLE_BITS];
         OP_MY1:  tx_ff   <= t_w;
         OP_MX2:  ty_ff   <= t_w;
         default: ;
      endcase
      if (cmd.load_out) begin
         out_ff <= {to_q15(cos_q), to_q15(sin_q), posy_ff, posx_ff, turn_ff, lin_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= '0;
         posx_ff    <= '0;
         posy_ff    <= '0;
      end else begin
         case (cmd.op)
            OP_HUPD: heading_ff <= heading_ff + hd_ff;
            OP_MY2:  posx_ff    <= pos_new_w;
            OP_PY:   posy_ff    <= pos_new_w;
            default: ;
         endcase
      end
   end

   odo_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.cordic_start),
      .angle_a (a32_w + a32_w),
      .angle_b (a32_w),
      .done    (cdone),
      .cos_a   (cos_h),
      .sin_a   (sin_h),
      .cos_b   (cos_q),
      .sin_b   (sin_q)
   );

   assign sts.cordic_done = cdone;
   assign rsp_tdata       = out_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/odo_ctrl.sv -----
`default_nettype none
module odo_ctrl import odo_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output odo_cmd_type      cmd,
   input  wire odo_sts_type sts
);

   typedef enum logic [4:0] {
      S_IDLE, S_LIN, S_P1, S_TLO, S_THI, S_HLO, S_HHI, S_HEAD, S_HUPD,
      S_CSTART, S_CWAIT, S_MX1, S_MY1, S_MX2, S_MY2, S_PY, S_DONE
   } state_type;

   state_type state_ff;
   op_type    op_ff;
   logic      cstart_ff;
   logic      rsp_tvalid_ff;
   logic      accept_w;
   logic      load_out_w;

   assign accept_w   = req_tvalid && (state_ff == S_IDLE);
   assign load_out_w = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_NONE;
         cstart_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cstart_ff <= 1'b0;
         if (load_out_w) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept_w) begin
                  state_ff <= S_LIN;
                  op_ff    <= OP_LIN;
               end
            end
            S_LIN: begin
               state_ff <= S_P1;
               op_ff    <= OP_P1;
            end
            S_P1: begin
               state_ff <= S_TLO;
               op_ff    <= OP_TLO;
            end
            S_TLO: begin
               state_ff <= S_THI;
               op_ff    <= OP_THI;
            end
            S_THI: begin
               state_ff <= S_HLO;
               op_ff    <= OP_HLO;
            end
            S_HLO: begin
               state_ff <= S_HHI;
               op_ff    <= OP_HHI;
            end
            S_HHI: begin
               state_ff <= S_HEAD;
               op_ff    <= OP_HEAD;
            end
            S_HEAD: begin
               state_ff <= S_HUPD;
               op_ff    <= OP_HUPD;
            end
            S_HUPD: begin
               state_ff  <= S_CSTART;
               op_ff     <= OP_NONE;
               cstart_ff <= 1'b1;
            end
            S_CSTART: begin
               state_ff <= S_CWAIT;
            end
            S_CWAIT: begin
               if (sts.cordic_done) begin
                  state_ff <= S_MX1;
                  op_ff    <= OP_MX1;
               end
            end
            S_MX1: begin
               state_ff <= S_MY1;
               op_ff    <= OP_MY1;
            end
            S_MY1: begin
               state_ff <= S_MX2;
               op_ff    <= OP_MX2;
            end
            S_MX2: begin
               state_ff <= S_MY2;
               op_ff    <= OP_MY2;
            end
            S_MY2: begin
               state_ff <= S_PY;
               op_ff    <= OP_PY;
            end
            S_PY: begin
               state_ff <= S_DONE;
               op_ff    <= OP_NONE;
            end
            S_DONE: begin
               if (load_out_w) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               op_ff    <= OP_NONE;
            end
         endcase
      end
   end

   always_comb begin
      cmd.op           = op_ff;
      cmd.cordic_start = cstart_ff;
      cmd.load_in      = accept_w;
      cmd.load_out     = load_out_w;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept_w |=> (state_ff == S_LIN))
      else $error("transaction accepted but sequence not started");

   a_cordic_done_wait: assert property (@(posedge clock) disable iff (reset)
      sts.cordic_done |-> (state_ff == S_CWAIT))
      else $error("rotator finished outside its wait state");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_out_w |=> rsp_tvalid_ff)
      else $error("result loaded but not presented");

   a_no_start_twice: assert property (@(posedge clock) disable iff (reset)
      cstart_ff |=> !cstart_ff)
      else $error("rotator started on consecutive cycles");

endmodule
`default_nettype wire

// ----- hw/rtl/diff_drive_odometry.sv -----
// Transactions do not overlap; the shared multiplier is used ten times in sequence
// and the rotator iterates one step per cycle.
// A new input is taken while the previous result still waits on the output register.
// Reset (synchronous): heading, position, CSR coefficients and control state cleared, output empty.
`default_nettype none
module diff_drive_odometry import odo_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int unsigned ANGLE_BITS   = ANGLE_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // left_rpm, right_rpm
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [159:0]      rsp_tdata,   // linear_speed, turn_rate, pos_x, pos_y, quat_z, quat_w
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [23:0]  lin_coef_ff, ang_coef_ff, step_period_ff;
   logic         wr_w;
   csr_idx_type  idx_w;
   odo_cmd_type  cmd;
   odo_sts_type  sts;

   assign csr_pready = 1'b1;
   assign wr_w       = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx_w      = csr_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_coef_ff    <= '0;
         ang_coef_ff    <= '0;
         step_period_ff <= '0;
      end else if (wr_w) begin
         case (idx_w)
            CSR_LIN_COEF:    lin_coef_ff    <= csr_pwdata[23:0];
            CSR_ANG_COEF:    ang_coef_ff    <= csr_pwdata[23:0];
            CSR_STEP_PERIOD: step_period_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx_w)
         CSR_LIN_COEF:    csr_prdata = {8'b0, lin_coef_ff};
         CSR_ANG_COEF:    csr_prdata = {8'b0, ang_coef_ff};
         CSR_STEP_PERIOD: csr_prdata = {8'b0, step_period_ff};
         default:         csr_prdata = '0;
      endcase
   end

   odo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   odo_dp #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .ANGLE_BITS   (ANGLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .lin_coef    (lin_coef_ff),
      .ang_coef    (ang_coef_ff),
      .step_period (step_period_ff),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
`default_nettype wire
